[rtl/binary_image_component_counter_unit_defines.svh]
// Assertion macros shared by the component counter RTL.
`ifndef BINARY_IMAGE_COMPONENT_COUNTER_UNIT_DEFINES_SVH
`define BINARY_IMAGE_COMPONENT_COUNTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BICC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BICC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define BICC_ASSERT(label, clk, rst_n, prop, msg)
`define BICC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/bicc_pkg.sv]
// Package with constants and types for the component counter.
`default_nettype none
package bicc_pkg;
	localparam int unsigned MaxRowsDef = 64;
	localparam int unsigned MaxColsDef = 64;
	localparam int unsigned SizeW = 7;
	localparam int unsigned CountW = 11;
	localparam int unsigned CellW = 13;
	localparam logic [CountW-1:0] TallyMax = 11'd2047;
	localparam logic [0:0] RegRows = 1'b0;
	localparam logic [0:0] RegCols = 1'b1;
endpackage
`default_nettype wire

[rtl/bicc_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module bicc_ram #(
	parameter int unsigned Width = 1,
	parameter int unsigned Depth = 4096
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/binary_image_component_counter_unit.sv]
// Top level: loads a binary image and counts its 8-connected components.
// Channels: the input channel carries one pixel per transaction (valid/stall),
// in row-major order. The configuration channel (cfg_valid/cfg_ready, with
// cfg_index and cfg_data) writes num_rows (index 0) and num_cols (index 1).
// The output channel carries one transaction per image: component_count and
// cell_count, held while stall is high.
// Loading accepts a pixel whenever in_valid is high. After the last pixel a
// sequencer scans the image in raster order and flood-fills every new
// component with a stack memory. Each cell of the scan reads the pixel memory
// in S_SCAN and checks the registered data in S_SCHK, and each cell pushed
// onto the stack costs nine neighbour probes (S_PRB, S_PCHK) plus a pop. The
// pace of the count is set by the single read port of the pixel memory.
// Visited marks are a second bit of the pixel memory, cleared as each pixel
// loads.
// Reset returns to loading at position zero with a 64 by 64 image. While the
// result waits for a stalled receiver the block accepts no pixel.
`default_nettype none
`include "binary_image_component_counter_unit_defines.svh"
module binary_image_component_counter_unit #(
	parameter int unsigned MAX_ROWS = bicc_pkg::MaxRowsDef,
	parameter int unsigned MAX_COLS = bicc_pkg::MaxColsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic pixel,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [bicc_pkg::SizeW-1:0] cfg_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic [bicc_pkg::CountW-1:0] component_count,
	output logic [bicc_pkg::CellW-1:0] cell_count
);
	import bicc_pkg::*;
	localparam int unsigned Cells = MAX_ROWS * MAX_COLS;
	localparam int unsigned AW = (Cells > 1) ? $clog2(Cells) : 1;
	localparam int unsigned PW = $clog2(Cells + 1);
	localparam int unsigned RW = $clog2(MAX_ROWS + 1);
	localparam int unsigned CW = $clog2(MAX_COLS + 1);
	localparam int unsigned SW = RW + CW;

	typedef enum logic [6:0] {
		S_LOAD = 7'b0000001,
		S_SCAN = 7'b0000010,
		S_SCHK = 7'b0000100,
		S_POP  = 7'b0001000,
		S_PRB  = 7'b0010000,
		S_PCHK = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [SizeW-1:0] rows_reg_q, cols_reg_q;
	logic [RW-1:0] rows, rows_q;
	logic [CW-1:0] cols, cols_q;
	logic [PW-1:0] pos_q, total;
	logic [AW-1:0] scan_q;
	logic [RW-1:0] srow_q, crow_q;
	logic [CW-1:0] scol_q, ccol_q;
	logic [3:0] nb_q;
	logic [1:0] nb_row, nb_col;
	logic [RW:0] nr;
	logic [CW:0] nc;
	logic nb_ok;
	logic [SW-1:0] nsum;
	logic [AW-1:0] nidx, nidx_q;
	logic [PW-1:0] sp_q;
	logic [CountW-1:0] tally_q;
	logic [CellW-1:0] cells_q;
	logic pm_we;
	logic [1:0] pm_wdata, pm_rd;
	logic [AW-1:0] pm_raddr, pm_waddr;
	logic st_we;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [SW-1:0] st_rd;
	logic accept, last;

	always_comb begin
		rows = (rows_reg_q == '0) ? RW'(1)
			: ({25'd0, rows_reg_q} > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_reg_q);
		cols = (cols_reg_q == '0) ? CW'(1)
			: ({25'd0, cols_reg_q} > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_reg_q);
		total = PW'(rows) * PW'(cols);
	end

	assign in_stall = (state_q != S_LOAD);
	assign cfg_ready = 1'b1;
	assign accept = in_valid && !in_stall;
	assign last = (pos_q + PW'(1)) >= total;
	assign out_valid = (state_q == S_OUT);
	assign component_count = tally_q;
	assign cell_count = cells_q;

	always_comb begin
		unique case (nb_q)
			4'd0, 4'd1, 4'd2: nb_row = 2'd0;
			4'd3, 4'd4, 4'd5: nb_row = 2'd1;
			default: nb_row = 2'd2;
		endcase
		unique case (nb_q)
			4'd0, 4'd3, 4'd6: nb_col = 2'd0;
			4'd1, 4'd4, 4'd7: nb_col = 2'd1;
			default: nb_col = 2'd2;
		endcase
		nr = {1'b0, crow_q} + (RW+1)'(nb_row) - (RW+1)'(1);
		nc = {1'b0, ccol_q} + (CW+1)'(nb_col) - (CW+1)'(1);
		nb_ok = !nr[RW] && !nc[CW] && (nr[RW-1:0] < rows_q) && (nc[CW-1:0] < cols_q);
		nsum = {{CW{1'b0}}, nr[RW-1:0]} * {{RW{1'b0}}, cols_q} + {{RW{1'b0}}, nc[CW-1:0]};
		nidx = nsum[AW-1:0];
	end

	assign pm_raddr = (state_q == S_SCAN) ? scan_q : nidx;
	assign st_raddr = AW'(sp_q - PW'(1));

	always_comb begin
		pm_we = 1'b0;
		pm_waddr = pos_q[AW-1:0];
		pm_wdata = {1'b0, pixel};
		priority if (state_q == S_LOAD) begin
			pm_we = accept && ({1'b0, pos_q} < (PW+1)'(Cells));
		end else if (state_q == S_SCHK) begin
			pm_we = pm_rd[0] && !pm_rd[1];
			pm_waddr = scan_q;
			pm_wdata = 2'b11;
		end else if (state_q == S_PCHK) begin
			pm_we = st_we;
			pm_waddr = nidx_q;
			pm_wdata = 2'b11;
		end
	end

	bicc_ram #(.Width(2), .Depth(Cells)) u_pix (
		.clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
		.raddr(pm_raddr), .rdata(pm_rd)
	);
	bicc_ram #(.Width(SW), .Depth(Cells)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata({nr[RW-1:0], nc[CW-1:0]}),
		.raddr(st_raddr), .rdata(st_rd)
	);

	always_comb begin
		st_we = 1'b0;
		st_waddr = sp_q[AW-1:0];
		if (state_q == S_PCHK && nb_ok && pm_rd[0] && !pm_rd[1]) begin
			st_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			rows_reg_q <= SizeW'(64);
			cols_reg_q <= SizeW'(64);
			pos_q <= '0;
			tally_q <= '0;
			sp_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					RegRows: rows_reg_q <= cfg_data;
					RegCols: cols_reg_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (last) begin
							pos_q <= '0;
							rows_q <= rows;
							cols_q <= cols;
							cells_q <= CellW'(total);
							tally_q <= '0;
							scan_q <= '0;
							srow_q <= '0;
							scol_q <= '0;
							state_q <= S_SCAN;
						end else begin
							pos_q <= pos_q + PW'(1);
						end
					end
				end
				S_SCAN: state_q <= S_SCHK;
				S_SCHK: begin
					if (pm_rd[0] && !pm_rd[1]) begin
						if (tally_q != TallyMax) begin
							tally_q <= tally_q + CountW'(1);
						end
						crow_q <= srow_q;
						ccol_q <= scol_q;
						nb_q <= '0;
						sp_q <= '0;
						state_q <= S_PRB;
					end else begin
						state_q <= S_POP;
						sp_q <= '0;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						if ({1'b0, scan_q} + (AW+1)'(1) >= (AW+1)'(cells_q)) begin
							state_q <= S_OUT;
						end else begin
							scan_q <= scan_q + AW'(1);
							if (scol_q + CW'(1) == cols_q) begin
								scol_q <= '0;
								srow_q <= srow_q + RW'(1);
							end else begin
								scol_q <= scol_q + CW'(1);
							end
							state_q <= S_SCAN;
						end
					end else begin
						crow_q <= st_rd[SW-1:CW];
						ccol_q <= st_rd[CW-1:0];
						sp_q <= sp_q - PW'(1);
						nb_q <= '0;
						state_q <= S_PRB;
					end
				end
				S_PRB: begin
					nidx_q <= nidx;
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (st_we && nb_q == 4'd8) begin
						// The last neighbour is pushed and popped at once.
						crow_q <= nr[RW-1:0];
						ccol_q <= nc[CW-1:0];
						nb_q <= '0;
						state_q <= S_PRB;
					end else begin
						if (st_we) begin
							sp_q <= sp_q + PW'(1);
						end
						if (nb_q == 4'd8) begin
							state_q <= S_POP;
						end else begin
							nb_q <= nb_q + 4'd1;
							state_q <= S_PRB;
						end
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	`BICC_ASSERT(a_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`BICC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(component_count), "result dropped under stall")
	`BICC_ASSERT(a_stack, clk, arst_n, ({1'b0, sp_q} <= (PW+1)'(Cells)), "stack overflow")
	`BICC_ASSERT_NEXT(a_start, clk, arst_n, accept && last, state_q == S_SCAN && tally_q == '0, "count did not start")
endmodule
`default_nettype wire
